// File: rtl/llf_pkg.sv
// shared types, constants and the microcode program of the ladder lowpass filter
// no dependencies; used by the sequencer, the datapath and the top level
package llf_pkg;

  localparam int PC_W        = 4;
  localparam int GAIN_W      = 16;
  localparam int FB_W        = 19;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 19;
  localparam int ROUND_SHIFT = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_STAGE_GAIN    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_GAIN = 2'd1;

  localparam logic [GAIN_W-1:0] STAGE_GAIN_RESET    = 16'd32768;
  localparam logic [FB_W-1:0]   FEEDBACK_GAIN_RESET = 19'd0;

  // program entry points
  localparam logic [PC_W-1:0] STEP_LOAD = 4'd0;
  localparam logic [PC_W-1:0] STEP_PASS = 4'd1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_FB,
    OP_SUB_X,
    OP_MUL_G,
    OP_ADD_S,
    OP_AVG,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_FIRST,
    JMP_ALWAYS
  } jmp_t;

  typedef struct packed {
    op_t             op;
    logic [1:0]      stage;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] stage;
    logic       fire;
  } ctl_t;

  // control store: one pass is steps 1 to 11, run twice per item
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, stage: 2'd0, jmp: JMP_ALWAYS, target: STEP_LOAD};
    unique case (pc)
      4'd0:    w = '{op: OP_LOAD,   stage: 2'd0, jmp: JMP_NONE,   target: STEP_LOAD};
      4'd1:    w = '{op: OP_MUL_FB, stage: 2'd0, jmp: JMP_NONE,   target: STEP_LOAD};
      4'd2:    w = '{op: OP_SUB_X,  stage: 2'd0, jmp: JMP_NONE,   target: STEP_LOAD};
      4'd3:    w = '{op: OP_MUL_G,  stage: 2'd0, jmp: JMP_NONE,   target: STEP_LOAD};
      4'd4:    w = '{op: OP_ADD_S,  stage: 2'd0, jmp: JMP_NONE,   target: STEP_LOAD};
      4'd5:    w = '{op: OP_MUL_G,  stage: 2'd1, jmp: JMP_NONE,   target: STEP_LOAD};
      4'd6:    w = '{op: OP_ADD_S,  stage: 2'd1, jmp: JMP_NONE,   target: STEP_LOAD};
      4'd7:    w = '{op: OP_MUL_G,  stage: 2'd2, jmp: JMP_NONE,   target: STEP_LOAD};
      4'd8:    w = '{op: OP_ADD_S,  stage: 2'd2, jmp: JMP_NONE,   target: STEP_LOAD};
      4'd9:    w = '{op: OP_MUL_G,  stage: 2'd3, jmp: JMP_NONE,   target: STEP_LOAD};
      4'd10:   w = '{op: OP_ADD_S,  stage: 2'd3, jmp: JMP_NONE,   target: STEP_LOAD};
      4'd11:   w = '{op: OP_AVG,    stage: 2'd0, jmp: JMP_FIRST,  target: STEP_PASS};
      4'd12:   w = '{op: OP_EMIT,   stage: 2'd0, jmp: JMP_ALWAYS, target: STEP_LOAD};
      default: w = '{op: OP_NOP,    stage: 2'd0, jmp: JMP_ALWAYS, target: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/llf_seq.sv
// microcode sequencer: step counter, pass flag and control store lookup
// depends on llf_pkg
module llf_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_free,
  output llf_pkg::ctl_t ctl
);

  logic [llf_pkg::PC_W-1:0] pc_r;
  logic [llf_pkg::PC_W-1:0] pc_nxt;
  logic                     pass_r;
  logic                     pass_nxt;
  llf_pkg::uword_t          word;
  logic                     stall;

  assign word = llf_pkg::ucode(pc_r);

  always_comb begin
    stall = 1'b0;
    if (word.op == llf_pkg::OP_LOAD && !in_valid) begin
      stall = 1'b1;
    end
    // result register still full
    if (word.op == llf_pkg::OP_EMIT && !out_free) begin
      stall = 1'b1;
    end
  end

  always_comb begin
    pc_nxt   = pc_r;
    pass_nxt = pass_r;
    if (!stall) begin
      if (word.jmp == llf_pkg::JMP_ALWAYS ||
          (word.jmp == llf_pkg::JMP_FIRST && !pass_r)) begin
        pc_nxt = word.target;
      end else begin
        pc_nxt = pc_r + llf_pkg::PC_W'(1);
      end
      if (word.op == llf_pkg::OP_AVG) begin
        pass_nxt = ~pass_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= llf_pkg::STEP_LOAD;
      pass_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      pass_r <= pass_nxt;
    end
  end

  assign ctl.op    = word.op;
  assign ctl.stage = word.stage;
  assign ctl.fire  = ~stall;

endmodule

// File: rtl/llf_datapath.sv
// filter datapath: state registers, one shared multiplier, round and saturate
// depends on llf_pkg; driven by the control word of llf_seq
module llf_datapath #(
  parameter int SAMPLE_WIDTH = 18,
  parameter int STATE_WIDTH  = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  llf_pkg::ctl_t                      ctl,
  input  logic signed [SAMPLE_WIDTH-1:0]     sample_in,
  input  logic [llf_pkg::GAIN_W-1:0]         stage_gain,
  input  logic [llf_pkg::FB_W-1:0]           feedback_gain,
  output logic signed [SAMPLE_WIDTH-1:0]     sample_out
);

  localparam int SW  = STATE_WIDTH;
  localparam int SW1 = SW + 1;
  localparam int DW  = SW + 1;
  localparam int CW  = llf_pkg::FB_W + 1;
  localparam int PW  = DW + CW;
  localparam int RW  = PW - llf_pkg::ROUND_SHIFT;
  localparam int AW  = RW + 1;
  localparam int SF  = SAMPLE_WIDTH - 4;
  localparam int TF  = SW - 4;

  logic signed [SW-1:0] s_r [4];
  logic signed [SW-1:0] hd_r;
  logic signed [SW-1:0] fv_r;
  logic signed [SW-1:0] xin_r;
  logic signed [SW-1:0] x_r;
  logic signed [PW-1:0] p_r;

  logic signed [SW-1:0] xin_conv;
  logic signed [CW-1:0] coef;
  logic signed [DW-1:0] mcand;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] p_half;
  logic signed [RW-1:0] rnd;
  logic signed [AW-1:0] acc;
  logic signed [SW-1:0] acc_sat;
  logic signed [SW:0]   avg_sum;
  logic signed [SW-1:0] avg;

  function automatic logic signed [SW-1:0] sat_acc(input logic signed [AW-1:0] v);
    if (&v[AW-1:SW-1] || ~|v[AW-1:SW-1]) begin
      return v[SW-1:0];
    end else if (v[AW-1]) begin
      return {1'b1, {(SW-1){1'b0}}};
    end else begin
      return {1'b0, {(SW-1){1'b1}}};
    end
  endfunction

  // input sample into the state format
  if (TF >= SF) begin : g_in_up
    assign xin_conv = SW'(sample_in) <<< (TF - SF);
  end else begin : g_in_down
    localparam int DIFF = SF - TF;
    localparam int IW   = SAMPLE_WIDTH + 1;
    logic signed [IW-1:0] in_rnd;
    logic signed [IW-1:0] in_sh;
    assign in_rnd = IW'(sample_in) + IW'(2 ** (DIFF - 1));
    assign in_sh  = in_rnd >>> DIFF;
    assign xin_conv = (&in_sh[IW-1:SW-1] || ~|in_sh[IW-1:SW-1]) ? in_sh[SW-1:0] :
                      in_sh[IW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
  end

  // feedback value into the sample format
  if (TF == SF) begin : g_out_same
    assign sample_out = fv_r;
  end else if (TF > SF) begin : g_out_down
    localparam int ODIFF = TF - SF;
    logic signed [SW:0] o_rnd;
    logic signed [SW:0] o_sh;
    assign o_rnd = SW1'(fv_r) + SW1'(2 ** (ODIFF - 1));
    assign o_sh  = o_rnd >>> ODIFF;
    assign sample_out =
      (&o_sh[SW:SAMPLE_WIDTH-1] || ~|o_sh[SW:SAMPLE_WIDTH-1]) ? o_sh[SAMPLE_WIDTH-1:0] :
      o_sh[SW] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  end else begin : g_out_up
    assign sample_out = SAMPLE_WIDTH'(fv_r) <<< (SF - TF);
  end

  always_comb begin
    if (ctl.op == llf_pkg::OP_MUL_FB) begin
      coef  = signed'({1'b0, feedback_gain});
      mcand = DW'(fv_r);
    end else begin
      coef  = signed'(CW'(stage_gain));
      mcand = DW'(x_r) - DW'(s_r[ctl.stage]);
    end
    prod   = PW'(coef) * PW'(mcand);
    // round half up, then drop the gain fraction
    p_half = p_r + PW'(2 ** (llf_pkg::ROUND_SHIFT - 1));
    rnd    = p_half[PW-1:llf_pkg::ROUND_SHIFT];
    if (ctl.op == llf_pkg::OP_SUB_X) begin
      acc = AW'(xin_r) - AW'(rnd);
    end else begin
      acc = AW'(s_r[ctl.stage]) + AW'(rnd);
    end
    acc_sat = sat_acc(acc);
    // floor of the half sum
    avg_sum = SW1'(x_r) + SW1'(hd_r);
    avg     = avg_sum[SW:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        s_r[i] <= '0;
      end
      hd_r <= '0;
      fv_r <= '0;
    end else if (ctl.fire) begin
      case (ctl.op)
        llf_pkg::OP_ADD_S: s_r[ctl.stage] <= acc_sat;
        llf_pkg::OP_AVG: begin
          fv_r <= avg;
          hd_r <= x_r;
        end
        default: ;
      endcase
    end
  end

  // x_r carries the cascade: the input less the feedback, then each new stage value, ending at stage four
  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      case (ctl.op) inside
        llf_pkg::OP_LOAD:                      xin_r <= xin_conv;
        llf_pkg::OP_MUL_FB, llf_pkg::OP_MUL_G: p_r <= prod;
        llf_pkg::OP_SUB_X, llf_pkg::OP_ADD_S:  x_r <= acc_sat;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/ladder_lowpass_filter.sv
// top level of the four-pole resonant ladder lowpass filter
// depends on llf_pkg, llf_seq and llf_datapath
//
//   channel  | ports                     | contents
//   ---------+---------------------------+----------------------------------
//   in       | in_tvalid/tready/tdata    | sample_in, signed, low bits
//   out      | out_tvalid/tready/tdata   | sample_out, signed, low bits
//   cfg      | cfg_valid/ready/index/data| 0 stage_gain, 1 feedback_gain
//
// an item runs through one load step, two passes of eleven microcode steps
// and one step into the result register; the ten dependent multiply and round
// steps of a pass all take turns on the single shared multiplier
// in_tready is high only in the load step; a full result register stalls the
// program at its last step until out_tready frees it
// rst_n is synchronous and clears the filter state and both gains to defaults
module ladder_lowpass_filter #(
  parameter int  SAMPLE_WIDTH = 18,
  parameter int  STATE_WIDTH  = 24,
  localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [TDATA_W-1:0]                in_tdata,   // sample_in
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [TDATA_W-1:0]                out_tdata,  // sample_out
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [llf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [llf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [llf_pkg::GAIN_W-1:0]     stage_gain_r;
  logic [llf_pkg::FB_W-1:0]       feedback_gain_r;
  logic                           out_tvalid_r;
  logic [SAMPLE_WIDTH-1:0]        out_data_r;
  logic                           out_free;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  llf_pkg::ctl_t                  ctl;

  assign cfg_ready = 1'b1;
  assign sample_in = in_tdata[SAMPLE_WIDTH-1:0];
  assign out_free  = ~out_tvalid_r | out_tready;
  assign in_tready = (ctl.op == llf_pkg::OP_LOAD);

  llf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .ctl      (ctl)
  );

  llf_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .sample_in     (sample_in),
    .stage_gain    (stage_gain_r),
    .feedback_gain (feedback_gain_r),
    .sample_out    (sample_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_gain_r    <= llf_pkg::STAGE_GAIN_RESET;
      feedback_gain_r <= llf_pkg::FEEDBACK_GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        llf_pkg::REG_STAGE_GAIN:    stage_gain_r    <= cfg_data[llf_pkg::GAIN_W-1:0];
        llf_pkg::REG_FEEDBACK_GAIN: feedback_gain_r <= cfg_data[llf_pkg::FB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctl.fire && ctl.op == llf_pkg::OP_EMIT) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.op == llf_pkg::OP_EMIT) begin
      out_data_r <= sample_out;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = TDATA_W'(out_data_r);

endmodule

// File: rtl/llf_checker.sv
// port-level checks for the ladder lowpass filter, bound to the top level
// depends only on the top level's ports
module llf_checker #(
  parameter int  SAMPLE_WIDTH = 18,
  localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic [TDATA_W-1:0] in_tdata,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata
);

  // a waiting input item stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input item changed while waiting");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // an accepted item closes the input as the first pass begins
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("input reopened during filter passes");

  // a new result is written in the last step, after which the load step follows
  a_emit_reload: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("input not ready after result written");

endmodule

bind ladder_lowpass_filter llf_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_llf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/ladder_lowpass_filter_test.sv
// self-checking testbench of the ladder lowpass filter: directed edge items, then shaped
// random sample runs under several gain settings, checked against a bit-exact predictor
// depends on llf_pkg and ladder_lowpass_filter
`timescale 1ns / 1ps

module ladder_lowpass_filter_test;

  localparam int SAMPLE_W   = 18;
  localparam int STATE_W    = 24;
  localparam int TDATA_W    = ((SAMPLE_W + 7) / 8) * 8;
  localparam int IN_SHIFT   = (STATE_W - 4) - (SAMPLE_W - 4);
  localparam int CYCLE_LIMIT = 1000000;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 18'sh1FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 18'sh20000;

  // register indexes with no register behind them
  localparam logic [llf_pkg::CFG_INDEX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [llf_pkg::CFG_INDEX_W-1:0] REG_UNUSED_B = 2'd3;

  typedef enum int {SHAPE_NOISE, SHAPE_HOLD, SHAPE_SQUARE, SHAPE_QUIET, SHAPE_IMPULSE} shape_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [TDATA_W-1:0]              in_tdata = '0;     // sample_in
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [TDATA_W-1:0]              out_tdata;         // sample_out
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [llf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [llf_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  ladder_lowpass_filter #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .STATE_WIDTH (STATE_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the filter
  logic [llf_pkg::GAIN_W-1:0] stage_gain_q;
  logic [llf_pkg::FB_W-1:0]   feedback_gain_q;
  logic signed [STATE_W-1:0]  ladder_stage [4];
  logic signed [STATE_W-1:0]  delay_tap;
  logic signed [STATE_W-1:0]  feedback_tap;

  logic signed [SAMPLE_W-1:0] expected_samples [$];
  logic signed [SAMPLE_W-1:0] oldest_sample;
  int                         failures = 0;
  int                         cycle_count = 0;
  bit                         steady = 1'b0;

  function automatic longint clamp(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // round to nearest, halves up; >>> on longint floors
  function automatic longint round_drop(input longint v, input int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] filter_sample(
      input logic signed [SAMPLE_W-1:0] s);
    longint x;
    longint drive;
    longint d;
    longint y;
    x = longint'(s) * (longint'(1) <<< IN_SHIFT);
    repeat (2) begin
      drive = clamp(x - round_drop(longint'(feedback_gain_q) * longint'(feedback_tap), 16),
                    STATE_W);
      for (int k = 0; k < 4; k++) begin
        d = drive - longint'(ladder_stage[k]);
        ladder_stage[k] = STATE_W'(clamp(longint'(ladder_stage[k])
                                + round_drop(d * longint'(stage_gain_q), 16), STATE_W));
        drive = ladder_stage[k];
      end
      feedback_tap = STATE_W'((longint'(ladder_stage[3]) + longint'(delay_tap)) >>> 1);
      delay_tap = ladder_stage[3];
    end
    y = clamp(round_drop(longint'(feedback_tap), IN_SHIFT), SAMPLE_W);
    return y[SAMPLE_W-1:0];
  endfunction

  // receiver stalls at random unless in a steady stretch
  always @(posedge clk) begin
    out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 29);
  end

  // both sides are stable at the falling edge, so the item taken at the next rise is known
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        failures++;
        $display("%0t: unexpected sample_out %0d, none expected", $time,
                 $signed(out_tdata[SAMPLE_W-1:0]));
      end else begin
        oldest_sample = expected_samples.pop_front();
        if (out_tdata[SAMPLE_W-1:0] !== oldest_sample) begin
          failures++;
          $display("%0t: sample_out expected %0d actual %0d", $time, oldest_sample,
                   $signed(out_tdata[SAMPLE_W-1:0]));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d samples outstanding", $time, expected_samples.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    logic signed [SAMPLE_W-1:0] predicted;
    gap = 0;
    if (!steady && $urandom_range(99) < 29) gap = $urandom_range(1, 30);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {{(TDATA_W - SAMPLE_W){1'b0}}, s};
    in_tvalid <= 1'b1;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    predicted = filter_sample(s);
    expected_samples = {expected_samples, predicted};
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [llf_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [llf_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == llf_pkg::REG_STAGE_GAIN) stage_gain_q = val[llf_pkg::GAIN_W-1:0];
    else if (idx == llf_pkg::REG_FEEDBACK_GAIN) feedback_gain_q = val;
    @(posedge clk);
  endtask

  task automatic set_gains(input logic [llf_pkg::CFG_DATA_W-1:0] g,
                           input logic [llf_pkg::CFG_DATA_W-1:0] fb);
    wait_drained();
    write_register(llf_pkg::REG_STAGE_GAIN, g);
    write_register(llf_pkg::REG_FEEDBACK_GAIN, fb);
  endtask

  // runs of noise, held levels, full-scale squares, quiet noise and impulses
  task automatic send_shaped_run(input int count);
    int left;
    int len;
    int period;
    shape_t shape;
    logic signed [SAMPLE_W-1:0] level;
    logic signed [SAMPLE_W-1:0] val;
    left = count;
    while (left > 0) begin
      len = $urandom_range(4, 40);
      if (len > left) len = left;
      shape = shape_t'($urandom_range(0, 4));
      level = SAMPLE_W'($urandom);
      if ($urandom_range(3) == 0) level = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      period = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        case (shape)
          SHAPE_NOISE:  val = SAMPLE_W'($urandom);
          SHAPE_HOLD:   val = level;
          SHAPE_SQUARE: val = ((k / period) % 2) ? SAMPLE_MAX : SAMPLE_MIN;
          SHAPE_QUIET: begin
            val = SAMPLE_W'($urandom_range(0, 511));
            val = val - 18'sd256;
          end
          default:      val = (k == 0) ? level : '0;
        endcase
        send_sample(val);
      end
      left -= len;
    end
  endtask

  // reset gains, full-scale steps and the smallest values
  task automatic test_default_settings();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(18'sd1);
    send_sample(-18'sd1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
  endtask

  // over-wide gain, feedback at its largest value, writes to unused indexes, frozen stages
  task automatic test_register_edges();
    wait_drained();
    write_register(llf_pkg::REG_STAGE_GAIN, 19'h7FFFF);
    write_register(llf_pkg::REG_FEEDBACK_GAIN, 19'h7FFFF);
    write_register(REG_UNUSED_A, llf_pkg::CFG_DATA_W'($urandom));
    write_register(REG_UNUSED_B, llf_pkg::CFG_DATA_W'($urandom));
    repeat (4) send_sample(SAMPLE_MAX);
    repeat (4) send_sample(SAMPLE_MIN);
    wait_drained();
    write_register(llf_pkg::REG_STAGE_GAIN, '0);
    send_sample(SAMPLE_MAX);
    send_sample(-18'sd1);
  endtask

  task automatic test_random_sweep();
    for (int setting = 0; setting < 8; setting++) begin
      case (setting)
        0:       set_gains(19'd65535, 19'd0);
        1:       set_gains(19'd0, 19'd327679);
        2:       set_gains(19'd65535, 19'd327679);
        3:       set_gains(19'd1, 19'h7FFFF);
        4:       set_gains(19'd32768, 19'd262144);
        default: set_gains(llf_pkg::CFG_DATA_W'($urandom_range(0, 65535)),
                           llf_pkg::CFG_DATA_W'($urandom_range(0, 524287)));
      endcase
      send_shaped_run(180);
    end
  endtask

  // no idling on either side, then random gaps and stalls with a stop until every result is back
  task automatic test_back_pressure();
    set_gains(llf_pkg::CFG_DATA_W'($urandom_range(0, 65535)),
              llf_pkg::CFG_DATA_W'($urandom_range(0, 327679)));
    steady = 1'b1;
    send_shaped_run(150);
    steady = 1'b0;
    send_shaped_run(20);
    wait_drained();
    send_shaped_run(20);
  endtask

  initial begin
    stage_gain_q    = llf_pkg::STAGE_GAIN_RESET;
    feedback_gain_q = llf_pkg::FEEDBACK_GAIN_RESET;
    for (int k = 0; k < 4; k++) ladder_stage[k] = '0;
    delay_tap    = '0;
    feedback_tap = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_settings();
    test_register_edges();
    test_random_sweep();
    test_back_pressure();

    wait_drained();
    repeat (60) @(posedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
